/* design/mlp_pkg.sv */
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types and constants for the integer perceptron with argmax readout.
// ----------------------------------------------------------------------------
package mlp_pkg;

  localparam int MAX_INPUTS  = 1024;
  localparam int MAX_HIDDEN  = 128;
  localparam int MAX_CLASSES = 16;
  localparam int PARAM_WORDS = 262144;

  localparam int PARAM_AW = $clog2(PARAM_WORDS);
  localparam int IN_AW    = $clog2(MAX_INPUTS);
  localparam int HID_AW   = $clog2(MAX_HIDDEN);
  localparam int CLS_AW   = $clog2(MAX_CLASSES);

  localparam int DATA_W   = 32;
  localparam int LEN_IN_W = 11;
  localparam int LEN_H_W  = 8;
  localparam int LEN_C_W  = 5;
  localparam int CFG_W    = 11;
  localparam int CFG_IW   = 2;

  localparam logic [CFG_IW-1:0] REG_INPUT_LENGTH = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HIDDEN_ONE   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_HIDDEN_TWO   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_CLASS_COUNT  = 2'd3;

  localparam logic CMD_PARAM = 1'b0;
  localparam logic CMD_INPUT = 1'b1;

  typedef struct packed {
    logic              command;
    logic [17:0]       address;
    logic signed [31:0] value;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         class_index;
    logic signed [31:0] best_score;
  } out_word_t;

  typedef enum logic [1:0] {
    LAYER_ONE,
    LAYER_TWO,
    LAYER_THREE
  } layer_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_DOT,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one operation travelling down the MAC pipe
  typedef struct packed {
    logic               valid;
    logic               is_bias;
    logic               last;
    logic [LEN_H_W-1:0] neuron;
  } op_t;

  typedef struct packed {
    logic               valid;
    logic [LEN_H_W-1:0] neuron;
    logic [DATA_W-1:0]  value;
  } result_t;

endpackage

/* design/mlp_ram.sv */
// ----------------------------------------------------------------------------
// mlp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlp_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/mlp_mac.sv */
// ----------------------------------------------------------------------------
// mlp_mac
// Shared multiply-accumulate unit: registered product, then 32-bit wrapping
// accumulate. Emits the finished neuron with optional ReLU.
// ----------------------------------------------------------------------------
module mlp_mac (
  input  logic                   clk,
  input  logic                   rst,
  input  mlp_pkg::op_t           op,
  input  logic [31:0]            weight,
  input  logic [31:0]            act,
  input  logic                   relu,
  output mlp_pkg::result_t       res,
  output logic                   busy
);
  import mlp_pkg::*;

  op_t               op2;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] mult;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sum;

  assign mult = weight * act;

  always_ff @(posedge clk) begin
    if (rst) begin
      op2.valid <= 1'b0;
    end else begin
      op2.valid <= op.valid;
    end
    op2.is_bias <= op.is_bias;
    op2.last    <= op.last;
    op2.neuron  <= op.neuron;
    prod        <= op.is_bias ? weight : mult;
  end

  assign sum = acc + prod;

  always_ff @(posedge clk) begin
    if (op2.valid) begin
      acc <= op2.is_bias ? prod : sum;
    end
  end

  always_comb begin
    res.valid  = op2.valid && !op2.is_bias && op2.last;
    res.neuron = op2.neuron;
    res.value  = (relu && sum[DATA_W-1]) ? '0 : sum;
  end

  assign busy = op2.valid;

endmodule

/* design/mlp_seq.sv */
// ----------------------------------------------------------------------------
// mlp_seq
// Inference sequencer: walks bias and weight addresses layer by layer and
// issues one bias or MAC operation per cycle to the shared unit, pausing to drain between layers.
// ----------------------------------------------------------------------------
module mlp_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mlp_pkg::LEN_IN_W-1:0]  input_length,
  input  logic [mlp_pkg::LEN_H_W-1:0]   hidden_one_length,
  input  logic [mlp_pkg::LEN_H_W-1:0]   hidden_two_length,
  input  logic [mlp_pkg::LEN_C_W-1:0]   class_count,
  input  logic                          mac_busy,
  input  logic                          out_free,
  output logic [mlp_pkg::PARAM_AW-1:0]  param_raddr,
  output logic [mlp_pkg::IN_AW-1:0]     act_raddr,
  output mlp_pkg::op_t                  op,
  output mlp_pkg::layer_t               layer,
  output logic                          busy,
  output logic                          finish
);
  import mlp_pkg::*;

  state_t               state, state_next;
  layer_t               layer_next;
  logic [LEN_IN_W-1:0]  rows_in, rows_in_next;
  logic [LEN_H_W-1:0]   rows_out, rows_out_next;
  logic [LEN_H_W-1:0]   len_b, len_b_next;
  logic [LEN_C_W-1:0]   len_c, len_c_next;
  logic [PARAM_AW-1:0]  bias_ptr, bias_ptr_next;
  logic [PARAM_AW-1:0]  weight_ptr, weight_ptr_next;
  logic [LEN_IN_W-1:0]  k, k_next;
  logic [LEN_H_W-1:0]   neuron, neuron_next;
  op_t                  issue;
  logic [LEN_IN_W-1:0]  n_cl;
  logic [LEN_H_W-1:0]   a_cl, b_cl;
  logic [LEN_C_W-1:0]   c_cl;
  logic                 k_last;

  always_comb begin
    n_cl = input_length;
    if (input_length == '0) n_cl = LEN_IN_W'(1);
    else if (input_length > LEN_IN_W'(MAX_INPUTS)) n_cl = LEN_IN_W'(MAX_INPUTS);
    a_cl = hidden_one_length;
    if (hidden_one_length == '0) a_cl = LEN_H_W'(1);
    else if (hidden_one_length > LEN_H_W'(MAX_HIDDEN)) a_cl = LEN_H_W'(MAX_HIDDEN);
    b_cl = hidden_two_length;
    if (hidden_two_length == '0) b_cl = LEN_H_W'(1);
    else if (hidden_two_length > LEN_H_W'(MAX_HIDDEN)) b_cl = LEN_H_W'(MAX_HIDDEN);
    c_cl = class_count;
    if (class_count == '0) c_cl = LEN_C_W'(1);
    else if (class_count > LEN_C_W'(MAX_CLASSES)) c_cl = LEN_C_W'(MAX_CLASSES);
  end

  assign k_last = (k == rows_in - LEN_IN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op.valid <= 1'b0;
    end else begin
      state    <= state_next;
      op.valid <= issue.valid;
    end
    op.is_bias <= issue.is_bias;
    op.last    <= issue.last;
    op.neuron  <= issue.neuron;
    layer      <= layer_next;
    rows_in    <= rows_in_next;
    rows_out   <= rows_out_next;
    len_b      <= len_b_next;
    len_c      <= len_c_next;
    bias_ptr   <= bias_ptr_next;
    weight_ptr <= weight_ptr_next;
    k          <= k_next;
    neuron     <= neuron_next;
  end

  always_comb begin
    state_next      = state;
    layer_next      = layer;
    rows_in_next    = rows_in;
    rows_out_next   = rows_out;
    len_b_next      = len_b;
    len_c_next      = len_c;
    bias_ptr_next   = bias_ptr;
    weight_ptr_next = weight_ptr;
    k_next          = k;
    neuron_next     = neuron;
    issue           = '0;
    issue.neuron    = neuron;
    param_raddr     = weight_ptr;
    finish          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          layer_next      = LAYER_ONE;
          rows_in_next    = n_cl;
          rows_out_next   = a_cl;
          len_b_next      = b_cl;
          len_c_next      = c_cl;
          bias_ptr_next   = '0;
          weight_ptr_next = PARAM_AW'(a_cl);
          k_next          = '0;
          neuron_next     = '0;
          state_next      = ST_BIAS;
        end
      end
      ST_BIAS: begin
        issue.valid   = 1'b1;
        issue.is_bias = 1'b1;
        param_raddr   = bias_ptr;
        bias_ptr_next = bias_ptr + PARAM_AW'(1);
        k_next        = '0;
        state_next    = ST_DOT;
      end
      ST_DOT: begin
        issue.valid     = 1'b1;
        issue.last      = k_last;
        weight_ptr_next = weight_ptr + PARAM_AW'(1);
        k_next          = k + LEN_IN_W'(1);
        if (k_last) begin
          if (neuron == rows_out - LEN_H_W'(1)) begin
            state_next = ST_DRAIN;
          end else begin
            neuron_next = neuron + LEN_H_W'(1);
            state_next  = ST_BIAS;
          end
        end
      end
      ST_DRAIN: begin
        if (!op.valid && !mac_busy) begin
          bias_ptr_next = weight_ptr;
          neuron_next   = '0;
          rows_in_next  = LEN_IN_W'(rows_out);
          unique case (layer)
            LAYER_ONE: begin
              layer_next      = LAYER_TWO;
              rows_out_next   = len_b;
              weight_ptr_next = weight_ptr + PARAM_AW'(len_b);
              state_next      = ST_BIAS;
            end
            LAYER_TWO: begin
              layer_next      = LAYER_THREE;
              rows_out_next   = LEN_H_W'(len_c);
              weight_ptr_next = weight_ptr + PARAM_AW'(len_c);
              state_next      = ST_BIAS;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign act_raddr = k[IN_AW-1:0];
  assign busy      = (state != ST_IDLE);

endmodule

/* design/three_layer_mlp_argmax.sv */
// ----------------------------------------------------------------------------
// three_layer_mlp_argmax
// Integer three-layer perceptron (ReLU, ReLU, linear) with argmax readout.
//
//   channel | signals                        | word
//   in      | in_valid, in_stall, in_word    | command, address, value, last
//   out     | out_valid, out_stall, out_word | class_index, best_score
//   cfg     | cfg_write, cfg_index, cfg_data | register write, no handshake
//
// Parameter and input writes are accepted while in_stall is low. An input
// word with last starts inference: each neuron gets a bias operation, then
// rows_in multiply-accumulates at one per cycle bound by the single parameter
// read port, and the MAC drains between layers. in_stall stays high until the
// result enters the output register, which waits while out_stall holds the
// previous result. Synchronous reset clears control; memories are not cleared.
// ----------------------------------------------------------------------------
module three_layer_mlp_argmax (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mlp_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mlp_pkg::out_word_t           out_word,
  input  logic                         cfg_write,
  input  logic [mlp_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [mlp_pkg::CFG_W-1:0]    cfg_data
);
  import mlp_pkg::*;

  logic [LEN_IN_W-1:0] input_length;
  logic [LEN_H_W-1:0]  hidden_one_length;
  logic [LEN_H_W-1:0]  hidden_two_length;
  logic [LEN_C_W-1:0]  class_count;

  logic                in_accept;
  logic                start;
  logic                param_we;
  logic                input_we;
  logic                busy;
  logic                finish;
  logic                out_free;
  logic                mac_busy;
  logic [PARAM_AW-1:0] param_raddr;
  logic [IN_AW-1:0]    act_raddr;
  logic [DATA_W-1:0]   param_rdata;
  logic [DATA_W-1:0]   in_rdata;
  logic [DATA_W-1:0]   h1_rdata;
  logic [DATA_W-1:0]   h2_rdata;
  logic [DATA_W-1:0]   act_rdata;
  logic                h1_we;
  logic                h2_we;
  op_t                 op;
  layer_t              layer;
  result_t             res;
  logic [CLS_AW-1:0]   best_idx;
  logic signed [DATA_W-1:0] best;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_length      <= LEN_IN_W'(784);
      hidden_one_length <= LEN_H_W'(128);
      hidden_two_length <= LEN_H_W'(128);
      class_count       <= LEN_C_W'(10);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INPUT_LENGTH: input_length      <= cfg_data[LEN_IN_W-1:0];
        REG_HIDDEN_ONE:   hidden_one_length <= cfg_data[LEN_H_W-1:0];
        REG_HIDDEN_TWO:   hidden_two_length <= cfg_data[LEN_H_W-1:0];
        REG_CLASS_COUNT:  class_count       <= cfg_data[LEN_C_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign param_we  = in_accept && (in_word.command == CMD_PARAM);
  assign input_we  = in_accept && (in_word.command == CMD_INPUT) &&
                     (in_word.address[17:IN_AW] == '0);
  assign start     = in_accept && (in_word.command == CMD_INPUT) && in_word.last;
  assign out_free  = !out_valid || !out_stall;

  mlp_ram #(.AW(PARAM_AW), .DW(DATA_W)) u_param_ram (
    .clk   (clk),
    .we    (param_we),
    .waddr (in_word.address[PARAM_AW-1:0]),
    .wdata (in_word.value),
    .raddr (param_raddr),
    .rdata (param_rdata)
  );

  mlp_ram #(.AW(IN_AW), .DW(DATA_W)) u_input_ram (
    .clk   (clk),
    .we    (input_we),
    .waddr (in_word.address[IN_AW-1:0]),
    .wdata (in_word.value),
    .raddr (act_raddr),
    .rdata (in_rdata)
  );

  assign h1_we = res.valid && (layer == LAYER_ONE);
  assign h2_we = res.valid && (layer == LAYER_TWO);

  mlp_ram #(.AW(HID_AW), .DW(DATA_W)) u_h1_ram (
    .clk   (clk),
    .we    (h1_we),
    .waddr (res.neuron[HID_AW-1:0]),
    .wdata (res.value),
    .raddr (act_raddr[HID_AW-1:0]),
    .rdata (h1_rdata)
  );

  mlp_ram #(.AW(HID_AW), .DW(DATA_W)) u_h2_ram (
    .clk   (clk),
    .we    (h2_we),
    .waddr (res.neuron[HID_AW-1:0]),
    .wdata (res.value),
    .raddr (act_raddr[HID_AW-1:0]),
    .rdata (h2_rdata)
  );

  mlp_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .input_length      (input_length),
    .hidden_one_length (hidden_one_length),
    .hidden_two_length (hidden_two_length),
    .class_count       (class_count),
    .mac_busy          (mac_busy),
    .out_free          (out_free),
    .param_raddr       (param_raddr),
    .act_raddr         (act_raddr),
    .op                (op),
    .layer             (layer),
    .busy              (busy),
    .finish            (finish)
  );

  always_comb begin
    case (layer)
      LAYER_ONE: act_rdata = in_rdata;
      LAYER_TWO: act_rdata = h1_rdata;
      default:   act_rdata = h2_rdata;
    endcase
  end

  mlp_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .weight (param_rdata),
    .act    (act_rdata),
    .relu   (layer != LAYER_THREE),
    .res    (res),
    .busy   (mac_busy)
  );

  // running argmax, first largest wins
  always_ff @(posedge clk) begin
    if (res.valid && (layer == LAYER_THREE)) begin
      if ((res.neuron == '0) || ($signed(res.value) > best)) begin
        best     <= $signed(res.value);
        best_idx <= res.neuron[CLS_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (finish) begin
      out_word.class_index <= best_idx;
      out_word.best_score  <= best;
    end
  end

endmodule
